// ----- rtl/wsfu_pkg.sv -----
// Package for the websocket frame unmasker: parse phase type and header field codes.
// No dependencies; imported by websocket_frame_unmasker_unit.
package wsfu_pkg;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_LEN     = 4'd1,
        PH_EXT_HI  = 4'd2,
        PH_EXT_LO  = 4'd3,
        PH_MASK0   = 4'd4,
        PH_MASK1   = 4'd5,
        PH_MASK2   = 4'd6,
        PH_MASK3   = 4'd7,
        PH_PAYLOAD = 4'd8,
        PH_DONE    = 4'd9
    } phase_t;

    localparam logic [3:0] OPCODE_CLOSE  = 4'h8;
    localparam logic [6:0] LEN_SHORT_MAX = 7'd125;
    localparam logic [6:0] LEN_EXT16     = 7'd126;

endpackage

// ----- rtl/websocket_frame_unmasker_unit.sv -----
// Websocket frame unmasker: parses frame headers and XORs payload bytes with the mask key.
// Depends on wsfu_pkg.
//
// Takes one received frame byte per cycle while s_tready is high (s_tuser marks the first
// byte of a frame) and gives at most one result per byte: an unmasked payload byte, with
// m_tlast on the final one, or a single empty-message result (m_tuser high, m_tdata zero)
// for a close opcode, length code 127 or zero length. Bytes outside a frame give nothing.
// Throughput is one byte per clock with back-to-back requests while m_tready is high. A
// request is held in the input register, and its result is loaded into the result register
// once that register is empty or m_tready is high, raising m_tvalid if the byte gives one.
// Header parse and unmask are combinational between the two registers. Backpressure on
// m_tready propagates to s_tready in the same cycle: while a result waits, one more byte
// can still enter an empty input register; then s_tready stays low until m_tready returns.
module websocket_frame_unmasker_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    input  logic       s_tuser,   // [0] frame_start
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] data_byte
    output logic       m_tlast,   // last_of_message
    output logic       m_tuser    // [0] empty_message
);
    import wsfu_pkg::*;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;

    // parser state
    phase_t      phase_reg, phase_next;
    logic [15:0] payload_length_reg, payload_length_next;
    logic [7:0]  mask_key_reg [4];
    logic [7:0]  mask_key_next [4];
    logic [15:0] byte_index_reg, byte_index_next;

    // result register
    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic       out_last_reg;
    logic       out_empty_reg;

    logic       advance;
    logic       res_valid;
    logic [7:0] res_data;
    logic       res_last;
    logic       res_empty;
    logic       pay_last;
    logic [6:0] len_code;
    logic [16:0] index_inc;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign len_code  = in_byte_reg[6:0];
    assign index_inc = {1'b0, byte_index_reg} + 17'd1;
    assign pay_last  = index_inc >= {1'b0, payload_length_reg};

    // next state
    always_comb begin
        phase_next          = phase_reg;
        payload_length_next = payload_length_reg;
        mask_key_next       = mask_key_reg;
        byte_index_next     = byte_index_reg;
        if (in_start_reg) begin
            payload_length_next = '0;
            byte_index_next     = '0;
            for (int k = 0; k < 4; k++) begin
                mask_key_next[k] = '0;
            end
            if (in_byte_reg[3:0] == OPCODE_CLOSE) begin
                phase_next = PH_DONE;
            end else begin
                phase_next = PH_LEN;
            end
        end else begin
            case (phase_reg)
                PH_LEN: begin
                    if (len_code <= LEN_SHORT_MAX) begin
                        payload_length_next = {9'd0, len_code};
                        phase_next = (len_code == 7'd0) ? PH_DONE : PH_MASK0;
                    end else if (len_code == LEN_EXT16) begin
                        phase_next = PH_EXT_HI;
                    end else begin
                        phase_next = PH_DONE;
                    end
                end
                PH_EXT_HI: begin
                    payload_length_next = {in_byte_reg, 8'd0};
                    phase_next = PH_EXT_LO;
                end
                PH_EXT_LO: begin
                    payload_length_next = {payload_length_reg[15:8], in_byte_reg};
                    phase_next = ({payload_length_reg[15:8], in_byte_reg} == 16'd0) ?
                                 PH_DONE : PH_MASK0;
                end
                PH_MASK0: begin
                    mask_key_next[0] = in_byte_reg;
                    phase_next = PH_MASK1;
                end
                PH_MASK1: begin
                    mask_key_next[1] = in_byte_reg;
                    phase_next = PH_MASK2;
                end
                PH_MASK2: begin
                    mask_key_next[2] = in_byte_reg;
                    phase_next = PH_MASK3;
                end
                PH_MASK3: begin
                    mask_key_next[3] = in_byte_reg;
                    byte_index_next  = '0;
                    phase_next = PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    byte_index_next = index_inc[15:0];
                    if (pay_last) begin
                        phase_next = PH_DONE;
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // result of the current request
    always_comb begin
        res_valid = 1'b0;
        res_data  = '0;
        res_last  = 1'b0;
        res_empty = 1'b0;
        if (in_start_reg) begin
            if (in_byte_reg[3:0] == OPCODE_CLOSE) begin
                res_valid = 1'b1;
                res_last  = 1'b1;
                res_empty = 1'b1;
            end
        end else begin
            case (phase_reg)
                PH_LEN: begin
                    if (len_code == 7'd0 || len_code > LEN_EXT16) begin
                        res_valid = 1'b1;
                        res_last  = 1'b1;
                        res_empty = 1'b1;
                    end
                end
                PH_EXT_LO: begin
                    if ({payload_length_reg[15:8], in_byte_reg} == 16'd0) begin
                        res_valid = 1'b1;
                        res_last  = 1'b1;
                        res_empty = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    res_valid = 1'b1;
                    res_data  = in_byte_reg ^ mask_key_reg[byte_index_reg[1:0]];
                    res_last  = pay_last;
                end
                default: begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_IDLE;
            payload_length_reg <= '0;
            byte_index_reg     <= '0;
            for (int k = 0; k < 4; k++) begin
                mask_key_reg[k] <= '0;
            end
        end else if (advance) begin
            phase_reg          <= phase_next;
            payload_length_reg <= payload_length_next;
            byte_index_reg     <= byte_index_next;
            mask_key_reg       <= mask_key_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_data_reg  <= res_data;
            out_last_reg  <= res_last;
            out_empty_reg <= res_empty;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_empty_reg;

    // an empty message is always a final, zero byte
    a_empty_form: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_empty_reg |-> out_last_reg && (out_data_reg == 8'd0))
        else $error("empty-message result without last flag or with data");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> byte_index_reg < payload_length_reg)
        else $error("payload index ran past payload length");

    a_close_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_start_reg && (in_byte_reg[3:0] == OPCODE_CLOSE)
        |=> out_valid_reg && out_empty_reg && (phase_reg == PH_DONE))
        else $error("close header did not give an empty message");

    a_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !in_start_reg && (phase_reg == PH_PAYLOAD) && pay_last
        |=> phase_reg == PH_DONE && out_valid_reg && out_last_reg)
        else $error("final payload byte did not close the frame");

endmodule
